[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker file tcw_checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, muted while reset is high
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// clocked property, checked during reset as well
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[hdl/tcw_pkg.sv]
// ---------------------------------------------------------------------------
// tcw_pkg
// shared types and constants of the text console writer
// ---------------------------------------------------------------------------
package tcw_pkg;

  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int NCOL_W   = 7;
  localparam int NROW_W   = 5;
  localparam int INDEX_W  = 11;
  localparam int POS_W    = 11;
  localparam int WORD_W   = 16;
  localparam int ATTR_W   = 8;
  localparam int COLOR_W  = 4;

  localparam logic [WORD_W-1:0] BLANK_CELL = 16'h0F20;
  localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_FIRST   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LAST    = 8'h7F;
  localparam int                TAB_STOP   = 8;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_SET   = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [0:0] {
    REG_FG = 1'b0,
    REG_BG = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic accept;
    logic sweep_clr;
    logic fill_step;
    logic scroll_step;
    logic load_result;
    logic load_read;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic scroll_needed;
    logic fill_done;
    logic scroll_done;
  } status_t;

endpackage

[hdl/tcw_ram.sv]
// ---------------------------------------------------------------------------
// tcw_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/tcw_ctrl.sv]
// ---------------------------------------------------------------------------
// tcw_ctrl
// sequencer: accepts requests, runs clear, scroll and read sequences
// ---------------------------------------------------------------------------
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  tcw_pkg::action_t  action,
  input  tcw_pkg::status_t  status,
  output tcw_pkg::cmd_t     cmd
);

  tcw_pkg::state_t state;
  tcw_pkg::state_t state_next;
  logic            accept;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tcw_pkg::ST_INIT: begin
        if (status.fill_done) state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          case (action)
            tcw_pkg::ACT_PUT: begin
              if (status.scroll_needed) state_next = tcw_pkg::ST_SCROLL;
            end
            tcw_pkg::ACT_CLEAR: state_next = tcw_pkg::ST_CLEAR;
            tcw_pkg::ACT_READ:  state_next = tcw_pkg::ST_READ;
            default:            state_next = tcw_pkg::ST_IDLE;
          endcase
        end
      end
      tcw_pkg::ST_READ:   state_next = tcw_pkg::ST_IDLE;
      tcw_pkg::ST_SCROLL: begin
        if (status.scroll_done) state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_CLEAR: begin
        if (status.fill_done) state_next = tcw_pkg::ST_IDLE;
      end
      default: state_next = tcw_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      tcw_pkg::ST_INIT: begin
        cmd.fill_step = 1'b1;
      end
      tcw_pkg::ST_IDLE: begin
        s_tready      = status.out_free;
        cmd.sweep_clr = 1'b1;
        cmd.accept    = accept;
        cmd.load_result = accept &&
          ((action == tcw_pkg::ACT_SET) ||
           ((action == tcw_pkg::ACT_PUT) && !status.scroll_needed));
      end
      tcw_pkg::ST_READ: begin
        cmd.load_read = 1'b1;
      end
      tcw_pkg::ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
        cmd.load_result = status.scroll_done;
      end
      tcw_pkg::ST_CLEAR: begin
        cmd.fill_step   = 1'b1;
        cmd.load_result = status.fill_done;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[hdl/tcw_datapath.sv]
// ---------------------------------------------------------------------------
// tcw_datapath
// cursor, sweep counter, cell store and result register
// ---------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tcw_pkg::cmd_t                   cmd,
  output tcw_pkg::status_t                status,
  input  tcw_pkg::action_t                action,
  input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
  input  logic [tcw_pkg::NCOL_W-1:0]      new_column,
  input  logic [tcw_pkg::NROW_W-1:0]      new_row,
  input  logic [tcw_pkg::INDEX_W-1:0]     cell_index,
  input  logic [tcw_pkg::ATTR_W-1:0]      attr,
  input  logic                            m_tready,
  output logic                            m_tvalid,
  output logic [tcw_pkg::POS_W-1:0]       cursor_position,
  output logic [tcw_pkg::WORD_W-1:0]      cell_word
);

  localparam int CELLS    = COLUMNS * ROWS;
  localparam int COPY_LEN = (ROWS - 1) * COLUMNS;
  localparam int AW       = $clog2(CELLS);
  localparam int CW       = $clog2(COLUMNS + tcw_pkg::TAB_STOP);
  localparam int RW       = $clog2(ROWS + 1);
  localparam int SW       = $clog2(CELLS + 2);

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic [CW-1:0] item_col;
  logic [RW-1:0] item_row;
  logic [CW-1:0] pc;
  logic [RW-1:0] pr;
  logic          printable;
  logic          scroll_needed;

  logic [AW-1:0] cur_pos;
  logic [AW-1:0] next_pos;

  logic [SW-1:0] sweep;
  logic [SW-1:0] sweep_m1;
  logic          rd_hit;
  logic          index_ok;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [tcw_pkg::WORD_W-1:0]  ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [tcw_pkg::WORD_W-1:0]  ram_rdata;

  // cursor after a put
  always_comb begin
    pc            = col;
    pr            = row;
    printable     = 1'b0;
    scroll_needed = 1'b0;
    if ((char_code == tcw_pkg::CH_BS) && (col != '0)) begin
      pc = col - CW'(1);
    end else if (char_code == tcw_pkg::CH_TAB) begin
      pc      = col + CW'(tcw_pkg::TAB_STOP);
      pc[2:0] = 3'b000;
    end else if (char_code == tcw_pkg::CH_CR) begin
      pc = '0;
    end else if (char_code == tcw_pkg::CH_LF) begin
      pc = '0;
      pr = row + RW'(1);
    end else if ((char_code >= tcw_pkg::CH_FIRST) && (char_code <= tcw_pkg::CH_LAST)) begin
      printable = 1'b1;
      pc        = col + CW'(1);
    end
    if (32'(pc) >= 32'(COLUMNS)) begin
      pc = '0;
      pr = pr + RW'(1);
    end
    if (32'(pr) >= 32'(ROWS)) begin
      pr            = RW'(ROWS - 1);
      scroll_needed = 1'b1;
    end
  end

  // cursor the accepted request leaves behind
  always_comb begin
    item_col = col;
    item_row = row;
    case (action)
      tcw_pkg::ACT_PUT: begin
        item_col = pc;
        item_row = pr;
      end
      tcw_pkg::ACT_CLEAR: begin
        item_col = '0;
        item_row = '0;
      end
      tcw_pkg::ACT_SET: begin
        item_col = (32'(new_column) >= 32'(COLUMNS)) ? CW'(COLUMNS - 1) : CW'(new_column);
        item_row = (32'(new_row) >= 32'(ROWS)) ? RW'(ROWS - 1) : RW'(new_row);
      end
      default: begin
        item_col = col;
        item_row = row;
      end
    endcase
  end

  assign col_next = cmd.accept ? item_col : col;
  assign row_next = cmd.accept ? item_row : row;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

  assign cur_pos  = AW'(AW'(row) * AW'(COLUMNS) + AW'(col));
  assign next_pos = AW'(AW'(row_next) * AW'(COLUMNS) + AW'(col_next));
  assign index_ok = 32'(cell_index) < 32'(CELLS);

  // sweep counter shared by clear and scroll
  assign sweep_m1 = sweep - SW'(1);

  always_ff @(posedge clk) begin
    if (rst || cmd.sweep_clr) begin
      sweep <= '0;
    end else if (cmd.fill_step || cmd.scroll_step) begin
      sweep <= sweep + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_hit <= index_ok;
    end
  end

  // store access
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_pos;
    ram_wdata = {attr, char_code};
    ram_re    = 1'b0;
    ram_raddr = AW'(cell_index);
    if (cmd.fill_step) begin
      ram_we    = 1'b1;
      ram_waddr = sweep[AW-1:0];
      ram_wdata = tcw_pkg::BLANK_CELL;
    end else if (cmd.scroll_step) begin
      ram_we    = (sweep != '0);
      ram_waddr = sweep_m1[AW-1:0];
      ram_wdata = (32'(sweep) <= 32'(COPY_LEN)) ? ram_rdata : tcw_pkg::BLANK_CELL;
      ram_re    = 32'(sweep) < 32'(COPY_LEN);
      ram_raddr = AW'(32'(sweep) + 32'(COLUMNS));
    end else if (cmd.accept) begin
      ram_we = (action == tcw_pkg::ACT_PUT) && printable;
      ram_re = (action == tcw_pkg::ACT_READ) && index_ok;
    end
  end

  tcw_ram #(
    .WIDTH (tcw_pkg::WORD_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_result || cmd.load_read) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result || cmd.load_read) begin
      cursor_position <= tcw_pkg::POS_W'(next_pos);
      cell_word       <= (cmd.load_read && rd_hit) ? ram_rdata : '0;
    end
  end

  assign status.out_free      = !m_tvalid || m_tready;
  assign status.scroll_needed = scroll_needed;
  assign status.fill_done     = 32'(sweep) == 32'(CELLS - 1);
  assign status.scroll_done   = 32'(sweep) == 32'(CELLS);

endmodule

[hdl/text_console_writer_unit.sv]
// ---------------------------------------------------------------------------
// text_console_writer_unit
// text console: cell store, cursor, character handling and scrolling
// ---------------------------------------------------------------------------
// put (no scroll), set cursor: result in the next cycle; one request a cycle unless stalled
// read cell: registered ram read, then result register; no new request until it is done
// clear: blanks every cell, one ram write per cycle
// put that scrolls: the row copy goes through the single ram port pair
// after reset a clearing pass blanks the store, s_tready low
// reset homes the cursor and sets foreground 15, background 0
module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // char_code[7:0], new_column[14:8], new_row[19:15],
                                 // cell_index[30:20], zero pad[31]
  input  logic [1:0]  s_tuser,   // action[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cursor_position[10:0], cell_word[26:11], zero pad[31:27]
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // colour registers
  logic [tcw_pkg::COLOR_W-1:0] fg;
  logic [tcw_pkg::COLOR_W-1:0] bg;
  logic                        reg_wr;
  tcw_pkg::reg_idx_t           reg_sel;

  // request fields
  tcw_pkg::action_t                action;
  logic [tcw_pkg::CHAR_W-1:0]      char_code;
  logic [tcw_pkg::NCOL_W-1:0]      new_column;
  logic [tcw_pkg::NROW_W-1:0]      new_row;
  logic [tcw_pkg::INDEX_W-1:0]     cell_index;

  // result fields
  logic [tcw_pkg::POS_W-1:0]       cursor_position;
  logic [tcw_pkg::WORD_W-1:0]      cell_word;

  // controller / datapath link
  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t status;

  // register port: always ready, registers at byte addresses 0 and 4
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = tcw_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= tcw_pkg::FG_RESET;
      bg <= tcw_pkg::BG_RESET;
    end else if (reg_wr) begin
      case (reg_sel)
        tcw_pkg::REG_FG: fg <= pwdata[tcw_pkg::COLOR_W-1:0];
        tcw_pkg::REG_BG: bg <= pwdata[tcw_pkg::COLOR_W-1:0];
        default:         fg <= fg;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tcw_pkg::REG_FG: prdata = 32'(fg);
      tcw_pkg::REG_BG: prdata = 32'(bg);
      default:         prdata = '0;
    endcase
  end

  // unpack the request
  assign action     = tcw_pkg::action_t'(s_tuser[1:0]);
  assign char_code  = s_tdata[7:0];
  assign new_column = s_tdata[14:8];
  assign new_row    = s_tdata[19:15];
  assign cell_index = s_tdata[30:20];

  // sequencer
  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .action   (action),
    .status   (status),
    .cmd      (cmd)
  );

  // cursor, store and result register; attribute is background high, foreground low
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .action          (action),
    .char_code       (char_code),
    .new_column      (new_column),
    .new_row         (new_row),
    .cell_index      (cell_index),
    .attr            ({bg, fg}),
    .m_tready        (m_tready),
    .m_tvalid        (m_tvalid),
    .cursor_position (cursor_position),
    .cell_word       (cell_word)
  );

  // pack the result
  assign m_tdata = {5'b0, cell_word, cursor_position};

endmodule

[hdl/tcw_checker.sv]
// ---------------------------------------------------------------------------
// tcw_checker
// port-level checks of the text console writer, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  localparam int CELLS = COLUMNS * ROWS;

  // no result is pending straight after reset
  `ASSERT_CLK(a_reset_empty, clk, rst |=> !m_tvalid, "result pending after reset")

  // while a result is pending, a request is only taken when it drains in the same cycle
  `ASSERT_CLK_RST(a_ready_needs_room, clk, rst, (s_tready && m_tvalid) |-> m_tready, "request taken over a stalled result")

  // a valid result's cursor lies on the screen (unchecked above 2048 cells)
  `ASSERT_CLK_RST(a_cursor_range, clk, rst, m_tvalid |-> ((CELLS > 2048) || (32'(m_tdata[10:0]) < 32'(CELLS))), "cursor off screen")

  // a stalled result holds
  `ASSERT_CLK_RST(a_result_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

endmodule

bind text_console_writer_unit tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
